// ----- rtl/video_phase_to_line_and_subcarrier_top_macros.svh -----
// Assertion macros shared by the phase-to-line RTL.
`ifndef VIDEO_PHASE_TO_LINE_AND_SUBCARRIER_TOP_MACROS_SVH
`define VIDEO_PHASE_TO_LINE_AND_SUBCARRIER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define VPLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vpls assertion failed");
`define VPLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vpls assertion failed");
`else
`define VPLS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define VPLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/vpls_pkg.sv -----
// Package with types and constants of the phase-to-line block.
package vpls_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 8;
    localparam int LINE_W    = 12;
    localparam int FINE_W    = 19;
    localparam int STEPS_W   = 9;

    localparam int LINES_G_DEF = 2500;
    localparam int LINES_M_DEF = 1050;

    localparam logic [DATA_W-1:0] FRAME_MOD_G = 32'd1105920000;
    localparam logic [DATA_W-1:0] FRAME_MOD_M = 32'd461260800;

    localparam logic [15:0] FAC_HI_G = 16'd43046;
    localparam logic [15:0] FAC_LO_G = 16'd11053;
    localparam logic [15:0] FAC_HI_M = 16'd34753;
    localparam logic [15:0] FAC_LO_M = 16'd61275;

    // Line period = odd divisor shifted left: G is 27 << 14, M is 429 << 10.
    localparam int SHIFT_G = 14;
    localparam int SHIFT_M = 10;
    localparam int REM_W   = 9;
    localparam logic [REM_W-1:0] DIV_G = 9'd27;
    localparam logic [REM_W-1:0] DIV_M = 9'd429;

    localparam int X_W       = DATA_W - SHIFT_M;
    localparam int Q_W       = 14;
    localparam int RECIP_SH  = 32;
    localparam int RECIP_W   = 28;
    localparam logic [RECIP_W-1:0] RECIP_G = RECIP_W'((64'd1 << RECIP_SH) / 27);
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((64'd1 << RECIP_SH) / 429);

    // Largest start line before the line-count wrap (quotient plus one).
    localparam logic [Q_W-1:0] Y_MAX = 14'd9777;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_H_CAL_G  = 8'd0,
        CFG_H_CAL_M  = 8'd1,
        CFG_OFFSET_G = 8'd2,
        CFG_OFFSET_M = 8'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] h_cal_g;
        logic [DATA_W-1:0] h_cal_m;
        logic [DATA_W-1:0] offset_g;
        logic [DATA_W-1:0] offset_m;
    } cfg_t;

    typedef struct packed {
        logic vld;
        logic system_g;
        logic blank_flag;
    } tag_t;

endpackage

// ----- rtl/vpls_item_if.sv -----
// Input item channel: requested phase and system flags.
interface vpls_item_if;
    logic                        valid;
    logic                        ready;
    logic [vpls_pkg::DATA_W-1:0] phase_value;
    logic                        system_g;
    logic                        blank_flag;

    modport source (output valid, output phase_value, output system_g,
                    output blank_flag, input ready);
    modport sink (input valid, input phase_value, input system_g,
                  input blank_flag, output ready);
endinterface

// ----- rtl/vpls_result_if.sv -----
// Result item channel: start line, fine phase, subcarrier steps and flags.
interface vpls_result_if;
    logic                         valid;
    logic                         ready;
    logic [vpls_pkg::LINE_W-1:0]  start_line;
    logic [vpls_pkg::FINE_W-1:0]  fine_phase;
    logic [vpls_pkg::STEPS_W-1:0] subcarrier_steps;
    logic                         system_g_out;
    logic                         blank_flag_out;

    modport source (output valid, output start_line, output fine_phase,
                    output subcarrier_steps, output system_g_out,
                    output blank_flag_out, input ready);
    modport sink (input valid, input start_line, input fine_phase,
                  input subcarrier_steps, input system_g_out,
                  input blank_flag_out, output ready);
endinterface

// ----- rtl/vpls_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface vpls_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [vpls_pkg::CFG_IDX_W-1:0] index;
    logic [vpls_pkg::DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/vpls_cfg_regs.sv -----
// Calibration and offset registers written over the configuration channel.
module vpls_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           we,
    input  logic [vpls_pkg::CFG_IDX_W-1:0] index,
    input  logic [vpls_pkg::DATA_W-1:0]    data,
    output vpls_pkg::cfg_t                 regs
);

    vpls_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (we)
        begin
            // Indexes outside the register list are dropped.
            unique case (index)
                vpls_pkg::CFG_H_CAL_G:  cfg_reg.h_cal_g  <= data;
                vpls_pkg::CFG_H_CAL_M:  cfg_reg.h_cal_m  <= data;
                vpls_pkg::CFG_OFFSET_G: cfg_reg.offset_g <= data;
                vpls_pkg::CFG_OFFSET_M: cfg_reg.offset_m <= data;
                default:                cfg_reg          <= cfg_reg;
            endcase
        end
    end

    assign regs = cfg_reg;

endmodule

// ----- rtl/vpls_phase_div.sv -----
// Total phase, division by the line period and subcarrier step stages.
`include "video_phase_to_line_and_subcarrier_top_macros.svh"
module vpls_phase_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_vld,
    input  logic [vpls_pkg::DATA_W-1:0]   phase_value,
    input  logic                          system_g,
    input  logic                          blank_flag,
    input  vpls_pkg::cfg_t                cfg,
    output vpls_pkg::tag_t                tag,
    output logic [vpls_pkg::Q_W-1:0]      y,
    output logic [vpls_pkg::FINE_W-1:0]   fine_phase,
    output logic [vpls_pkg::STEPS_W-1:0]  steps
);

    localparam int PROD_W = vpls_pkg::X_W + vpls_pkg::RECIP_W;
    localparam int QD_W   = vpls_pkg::X_W + 1;
    localparam int PF_W   = 24;
    localparam int SC_W   = PF_W + 1;

    vpls_pkg::tag_t a_tag_reg, b_tag_reg, c_tag_reg, d_tag_reg, e_tag_reg;

    logic [vpls_pkg::DATA_W-1:0]  a_phase_reg;
    logic [vpls_pkg::DATA_W-1:0]  b_total_reg;
    logic [vpls_pkg::DATA_W-1:0]  b_total_next;

    logic [vpls_pkg::X_W-1:0]     c_x_reg, c_x_next, d_x_reg;
    logic [vpls_pkg::SHIFT_G-1:0] c_low_reg, d_low_reg;
    logic [vpls_pkg::Q_W-1:0]     c_q0_reg, d_q0_reg;
    logic [vpls_pkg::STEPS_W-1:0] c_steps_reg, c_steps_next, d_steps_reg, e_steps_reg;
    logic [QD_W-1:0]              d_qd_reg, d_qd_next;
    logic [vpls_pkg::Q_W-1:0]     e_y_reg, e_y_next;
    logic [vpls_pkg::FINE_W-1:0]  e_fine_reg, e_fine_next;

    logic [PROD_W-1:0]            c_prod;
    logic [vpls_pkg::RECIP_W-1:0] c_recip;
    logic [7:0]                   c_byte;
    logic [15:0]                  c_fhi, c_flo;
    logic [PF_W-1:0]              c_hi_p, c_lo_p;
    logic [SC_W-1:0]              c_sc;
    logic [vpls_pkg::REM_W-1:0]   d_div, e_div;
    logic [QD_W-1:0]              e_diff;
    logic [vpls_pkg::REM_W:0]     e_r0, e_r1;
    logic                         e_corr;

    // Valid bits and flags move with the pipeline; the whole pipe stalls together.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tag_reg <= '0;
            b_tag_reg <= '0;
            c_tag_reg <= '0;
            d_tag_reg <= '0;
            e_tag_reg <= '0;
        end
        else if (adv)
        begin
            a_tag_reg <= '{vld: in_vld, system_g: system_g, blank_flag: blank_flag};
            b_tag_reg <= a_tag_reg;
            c_tag_reg <= b_tag_reg;
            d_tag_reg <= c_tag_reg;
            e_tag_reg <= d_tag_reg;
        end
    end

    // Total phase with 32-bit wrap.
    always_comb
    begin
        if (a_tag_reg.system_g)
        begin
            b_total_next = vpls_pkg::FRAME_MOD_G - a_phase_reg + cfg.h_cal_g + cfg.offset_g;
        end
        else
        begin
            b_total_next = vpls_pkg::FRAME_MOD_M - a_phase_reg + cfg.h_cal_m + cfg.offset_m;
        end
    end

    // Quotient estimate by reciprocal; it may be one short, fixed in the E-stage correction.
    always_comb
    begin
        if (b_tag_reg.system_g)
        begin
            c_x_next = vpls_pkg::X_W'(b_total_reg[vpls_pkg::DATA_W-1:vpls_pkg::SHIFT_G]);
            c_recip  = vpls_pkg::RECIP_G;
            c_fhi    = vpls_pkg::FAC_HI_G;
            c_flo    = vpls_pkg::FAC_LO_G;
        end
        else
        begin
            c_x_next = b_total_reg[vpls_pkg::DATA_W-1:vpls_pkg::SHIFT_M];
            c_recip  = vpls_pkg::RECIP_M;
            c_fhi    = vpls_pkg::FAC_HI_M;
            c_flo    = vpls_pkg::FAC_LO_M;
        end
        c_prod       = PROD_W'(c_x_next) * PROD_W'(c_recip);
        c_byte       = b_total_reg[7:0];
        c_hi_p       = PF_W'(c_byte) * PF_W'(c_fhi);
        c_lo_p       = PF_W'(c_byte) * PF_W'(c_flo);
        c_sc         = {c_hi_p, 1'b0} + SC_W'(c_lo_p[PF_W-1:15]);
        c_steps_next = c_sc[SC_W-1:16];
    end

    assign d_div     = d_tag_reg.system_g ? vpls_pkg::DIV_G : vpls_pkg::DIV_M;
    assign d_qd_next = QD_W'(c_q0_reg) * QD_W'(c_tag_reg.system_g ? vpls_pkg::DIV_G
                                                                   : vpls_pkg::DIV_M);

    // Remainder of the estimate lies below twice the divisor: one correction step.
    always_comb
    begin
        e_div    = d_div;
        e_diff   = {1'b0, d_x_reg} - d_qd_reg;
        e_r0     = e_diff[vpls_pkg::REM_W:0];
        e_corr   = (e_r0 >= {1'b0, e_div});
        e_r1     = e_corr ? (e_r0 - {1'b0, e_div}) : e_r0;
        e_y_next = d_q0_reg + (e_corr ? vpls_pkg::Q_W'(2) : vpls_pkg::Q_W'(1));
        if (d_tag_reg.system_g)
        begin
            e_fine_next = {e_r1[vpls_pkg::FINE_W-vpls_pkg::SHIFT_G-1:0],
                           d_low_reg[vpls_pkg::SHIFT_G-1:0]};
        end
        else
        begin
            e_fine_next = {e_r1[vpls_pkg::FINE_W-vpls_pkg::SHIFT_M-1:0],
                           d_low_reg[vpls_pkg::SHIFT_M-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_phase_reg <= phase_value;
            b_total_reg <= b_total_next;
            c_x_reg     <= c_x_next;
            c_low_reg   <= b_total_reg[vpls_pkg::SHIFT_G-1:0];
            c_q0_reg    <= c_prod[vpls_pkg::RECIP_SH +: vpls_pkg::Q_W];
            c_steps_reg <= c_steps_next;
            d_x_reg     <= c_x_reg;
            d_low_reg   <= c_low_reg;
            d_q0_reg    <= c_q0_reg;
            d_qd_reg    <= d_qd_next;
            d_steps_reg <= c_steps_reg;
            e_y_reg     <= e_y_next;
            e_fine_reg  <= e_fine_next;
            e_steps_reg <= d_steps_reg;
        end
    end

    assign tag        = e_tag_reg;
    assign y          = e_y_reg;
    assign fine_phase = e_fine_reg;
    assign steps      = e_steps_reg;

    `VPLS_ASSERT_NOW(a_y_range, clk, rst_n, e_tag_reg.vld,
                     (e_y_reg != '0) && (e_y_reg <= vpls_pkg::Y_MAX))
    `VPLS_ASSERT_NOW(a_est_close, clk, rst_n, d_tag_reg.vld, ({1'b0, d_x_reg} >= d_qd_reg))

endmodule

// ----- rtl/vpls_line_mod.sv -----
// Start line wrap by the line count and the result register.
`include "video_phase_to_line_and_subcarrier_top_macros.svh"
module vpls_line_mod
#(
    parameter int LINES_G = vpls_pkg::LINES_G_DEF,
    parameter int LINES_M = vpls_pkg::LINES_M_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  vpls_pkg::tag_t                tag,
    input  logic [vpls_pkg::Q_W-1:0]      y,
    input  logic [vpls_pkg::FINE_W-1:0]   fine_phase,
    input  logic [vpls_pkg::STEPS_W-1:0]  steps,
    output vpls_pkg::tag_t                out_tag,
    output logic [vpls_pkg::LINE_W-1:0]   start_line,
    output logic [vpls_pkg::FINE_W-1:0]   out_fine,
    output logic [vpls_pkg::STEPS_W-1:0]  out_steps
);

    localparam int LCNT_W  = vpls_pkg::LINE_W + 1;
    localparam int LREC_SH = vpls_pkg::Q_W + vpls_pkg::LINE_W;
    localparam int LP_W    = vpls_pkg::Q_W + LREC_SH;
    localparam int QL_W    = vpls_pkg::Q_W + LCNT_W;
    localparam logic [LCNT_W-1:0]  LEN_G   = LCNT_W'(LINES_G);
    localparam logic [LCNT_W-1:0]  LEN_M   = LCNT_W'(LINES_M);
    localparam logic [LREC_SH-1:0] LRCP_G  = LREC_SH'((64'd1 << LREC_SH) / LINES_G);
    localparam logic [LREC_SH-1:0] LRCP_M  = LREC_SH'((64'd1 << LREC_SH) / LINES_M);

    vpls_pkg::tag_t f_tag_reg, o_tag_reg;

    logic [vpls_pkg::Q_W-1:0]     f_y_reg, f_ql_reg;
    logic [vpls_pkg::FINE_W-1:0]  f_fine_reg, o_fine_reg;
    logic [vpls_pkg::STEPS_W-1:0] f_steps_reg, o_steps_reg;
    logic [vpls_pkg::LINE_W-1:0]  o_line_reg, o_line_next;

    logic [LP_W-1:0]   f_prod;
    logic [LCNT_W-1:0] g_len;
    logic [QL_W-1:0]   g_qll, g_diff;
    logic [LCNT_W-1:0] g_r0, g_r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_tag_reg <= '0;
            o_tag_reg <= '0;
        end
        else if (adv)
        begin
            f_tag_reg <= tag;
            o_tag_reg <= f_tag_reg;
        end
    end

    // Reciprocal estimate of y / lines, at most one short.
    assign f_prod = LP_W'(y) * LP_W'(tag.system_g ? LRCP_G : LRCP_M);

    always_comb
    begin
        g_len       = f_tag_reg.system_g ? LEN_G : LEN_M;
        g_qll       = QL_W'(f_ql_reg) * QL_W'(g_len);
        g_diff      = QL_W'(f_y_reg) - g_qll;
        g_r0        = g_diff[LCNT_W-1:0];
        g_r1        = (g_r0 >= g_len) ? (g_r0 - g_len) : g_r0;
        o_line_next = g_r1[vpls_pkg::LINE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_y_reg     <= y;
            f_ql_reg    <= f_prod[LREC_SH +: vpls_pkg::Q_W];
            f_fine_reg  <= fine_phase;
            f_steps_reg <= steps;
            o_line_reg  <= o_line_next;
            o_fine_reg  <= f_fine_reg;
            o_steps_reg <= f_steps_reg;
        end
    end

    assign out_tag    = o_tag_reg;
    assign start_line = o_line_reg;
    assign out_fine   = o_fine_reg;
    assign out_steps  = o_steps_reg;

    `VPLS_ASSERT_NOW(a_line_range, clk, rst_n, o_tag_reg.vld,
                     ({1'b0, o_line_reg} < (o_tag_reg.system_g ? LEN_G : LEN_M)))
    `VPLS_ASSERT_NOW(a_ql_bound, clk, rst_n, f_tag_reg.vld, f_ql_reg <= f_y_reg)
    `VPLS_ASSERT_NEXT(a_result_moves, clk, rst_n, f_tag_reg.vld && adv, o_tag_reg.vld)

endmodule

// ----- rtl/video_phase_to_line_and_subcarrier_top.sv -----
// Top level: phase to start line, fine phase and subcarrier steps.
// Throughput: one item per cycle; seven register stages, the two reciprocal multiplies
// and their correction steps set the depth.
// A stalled result freezes the whole pipeline, and the input is held off only then.
// Reset clears all valid bits and the four configuration registers to zero.
module video_phase_to_line_and_subcarrier_top
#(
    parameter int LINES_G = vpls_pkg::LINES_G_DEF,
    parameter int LINES_M = vpls_pkg::LINES_M_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    vpls_item_if.sink     item,
    vpls_result_if.source result,
    vpls_cfg_if.sink      cfg
);

    vpls_pkg::cfg_t                cfg_regs;
    vpls_pkg::tag_t                div_tag, out_tag;
    logic [vpls_pkg::Q_W-1:0]      div_y;
    logic [vpls_pkg::FINE_W-1:0]   div_fine;
    logic [vpls_pkg::STEPS_W-1:0]  div_steps;
    logic                          adv;

    // The pipeline moves whenever the result register is empty or being taken.
    assign adv        = !out_tag.vld || result.ready;
    assign item.ready = adv;
    assign cfg.ready  = 1'b1;

    vpls_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg.valid),
        .index (cfg.index),
        .data  (cfg.data),
        .regs  (cfg_regs)
    );

    vpls_phase_div u_phase_div
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_vld      (item.valid),
        .phase_value (item.phase_value),
        .system_g    (item.system_g),
        .blank_flag  (item.blank_flag),
        .cfg         (cfg_regs),
        .tag         (div_tag),
        .y           (div_y),
        .fine_phase  (div_fine),
        .steps       (div_steps)
    );

    vpls_line_mod
    #(
        .LINES_G (LINES_G),
        .LINES_M (LINES_M)
    )
    u_line_mod
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .tag        (div_tag),
        .y          (div_y),
        .fine_phase (div_fine),
        .steps      (div_steps),
        .out_tag    (out_tag),
        .start_line (result.start_line),
        .out_fine   (result.fine_phase),
        .out_steps  (result.subcarrier_steps)
    );

    assign result.valid          = out_tag.vld;
    assign result.system_g_out   = out_tag.system_g;
    assign result.blank_flag_out = out_tag.blank_flag;

endmodule

// ----- sim/vpls_line_checker.sv -----
// Checker that predicts start line, fine phase and subcarrier steps and compares them.
module vpls_line_checker
#(
    parameter int LINES_G = vpls_pkg::LINES_G_DEF,
    parameter int LINES_M = vpls_pkg::LINES_M_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    vpls_item_if   item,
    vpls_result_if result,
    vpls_cfg_if    cfg,
    output int     errors,
    output int     pending
);
    import vpls_pkg::*;

    localparam logic [DATA_W-1:0] PERIOD_G = 32'd442368;
    localparam logic [DATA_W-1:0] PERIOD_M = 32'd439296;

    typedef struct packed {
        logic [LINE_W-1:0]  start_line;
        logic [FINE_W-1:0]  fine_phase;
        logic [STEPS_W-1:0] steps;
        logic               system_g;
        logic               blank_flag;
    } line_result_t;

    logic [DATA_W-1:0] cal_g = '0;
    logic [DATA_W-1:0] cal_m = '0;
    logic [DATA_W-1:0] ofs_g = '0;
    logic [DATA_W-1:0] ofs_m = '0;
    int                fail_total = 0;
    int                queued = 0;
    line_result_t      predicted_lines[$];

    assign errors  = fail_total;
    assign pending = queued;

    function automatic line_result_t locate_line(input logic [DATA_W-1:0] phase,
                                                 input logic sys_g, input logic blank);
        logic [DATA_W-1:0] total;
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] lines;
        logic [DATA_W-1:0] fhi;
        logic [DATA_W-1:0] flo;
        logic [DATA_W-1:0] quot;
        logic [DATA_W-1:0] low;
        logic [DATA_W-1:0] sc;
        line_result_t      res;
        if (sys_g) begin
            total  = FRAME_MOD_G - phase + cal_g + ofs_g;
            period = PERIOD_G;
            lines  = LINES_G;
            fhi    = 32'(FAC_HI_G);
            flo    = 32'(FAC_LO_G);
        end
        else begin
            total  = FRAME_MOD_M - phase + cal_m + ofs_m;
            period = PERIOD_M;
            lines  = LINES_M;
            fhi    = 32'(FAC_HI_M);
            flo    = 32'(FAC_LO_M);
        end
        quot = total / period;
        low  = {24'd0, total[7:0]};
        // The low byte times the system factor, as a 16.16 product.
        sc   = (low * fhi) * 32'd2 + ((low * flo) >> 15);
        res.start_line = LINE_W'((quot + 32'd1) % lines);
        res.fine_phase = FINE_W'(total % period);
        res.steps      = STEPS_W'(sc >> 16);
        res.system_g   = sys_g;
        res.blank_flag = blank;
        return res;
    endfunction

    function automatic bit field_matches(input string name, input longint want,
                                         input longint got);
        if (want == got)
            return 1'b1;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1'b0;
    endfunction

    always @(posedge clk) begin
        line_result_t want;
        bit           ok;
        if (rst_n) begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_H_CAL_G:  cal_g = cfg.data;
                    CFG_H_CAL_M:  cal_m = cfg.data;
                    CFG_OFFSET_G: ofs_g = cfg.data;
                    CFG_OFFSET_M: ofs_m = cfg.data;
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
                predicted_lines.push_back(locate_line(item.phase_value, item.system_g,
                                                      item.blank_flag));
            if (result.valid && result.ready) begin
                if (predicted_lines.size() == 0) begin
                    $display("%0t: result transaction with none expected, start_line %0d",
                             $time, result.start_line);
                    fail_total <= fail_total + 1;
                end
                else begin
                    want = predicted_lines.pop_front();
                    ok = field_matches("start_line", want.start_line, result.start_line)
                       & field_matches("fine_phase", want.fine_phase, result.fine_phase)
                       & field_matches("subcarrier_steps", want.steps,
                                       result.subcarrier_steps)
                       & field_matches("system_g_out", want.system_g, result.system_g_out)
                       & field_matches("blank_flag_out", want.blank_flag,
                                       result.blank_flag_out);
                    if (!ok)
                        fail_total <= fail_total + 1;
                end
            end
            queued <= predicted_lines.size();
        end
    end

endmodule

// ----- sim/video_phase_to_line_and_subcarrier_top_tb.sv -----
// Testbench top: clock, reset, stimulus and verdict for the phase-to-line block.
module video_phase_to_line_and_subcarrier_top_tb;
    import vpls_pkg::*;

    localparam int LINES_G      = LINES_G_DEF;
    localparam int LINES_M      = LINES_M_DEF;
    localparam int IDLE_PCT     = 38;
    localparam int HOLD_CYCLES  = 150;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 12;

    localparam logic [DATA_W-1:0]    PERIOD_G       = 32'd442368;
    localparam logic [DATA_W-1:0]    PERIOD_M       = 32'd439296;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'hFC;

    typedef enum int {
        PICK_ANY,
        PICK_LINE_EDGE,
        PICK_LINE_WRAP,
        PICK_TOTAL_EDGE,
        PICK_NEAR_MOD
    } phase_pick_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    bit                tx_idle = 1'b1;
    bit                rx_idle = 1'b1;
    bit                hold_req = 1'b0;
    int                fail_count;
    int                pending_results;
    int                stall_cycles = 0;
    logic [DATA_W-1:0] cfg_shadow [4];

    vpls_item_if   item_ch();
    vpls_result_if result_ch();
    vpls_cfg_if    cfg_ch();

    video_phase_to_line_and_subcarrier_top
    #(
        .LINES_G (LINES_G),
        .LINES_M (LINES_M)
    )
    u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    vpls_line_checker
    #(
        .LINES_G (LINES_G),
        .LINES_M (LINES_M)
    )
    u_checker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .cfg     (cfg_ch),
        .errors  (fail_count),
        .pending (pending_results)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Any transaction on any channel counts as progress.
    always @(posedge clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles < STALL_LIMIT)
            stall_cycles <= stall_cycles + 1;
        else begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random back-pressure, and one long hold-off when asked.
    initial
    begin
        bit held;
        held = 1'b0;
        result_ch.ready <= 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_req && !held) begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_ch.ready <= !(rx_idle && $urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic logic [DATA_W-1:0] phase_giving_total(input logic sys_g,
                                                            input logic [DATA_W-1:0] total);
        if (sys_g)
            return FRAME_MOD_G + cfg_shadow[2'(CFG_H_CAL_G)] + cfg_shadow[2'(CFG_OFFSET_G)]
                   - total;
        return FRAME_MOD_M + cfg_shadow[2'(CFG_H_CAL_M)] + cfg_shadow[2'(CFG_OFFSET_M)]
               - total;
    endfunction

    // Valid stays high after a transaction; the next call either idles or offers again.
    task automatic send_phase(input logic [DATA_W-1:0] phase, input logic sys_g,
                              input logic blank);
        while (tx_idle && $urandom_range(99) < IDLE_PCT) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.phase_value <= phase;
        item_ch.system_g    <= sys_g;
        item_ch.blank_flag  <= blank;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        if (idx <= CFG_OFFSET_M)
            cfg_shadow[idx[1:0]] = value;
    endtask

    task automatic apply_calibration(input logic [DATA_W-1:0] hg, input logic [DATA_W-1:0] hm,
                                     input logic [DATA_W-1:0] og, input logic [DATA_W-1:0] om);
        write_reg(CFG_H_CAL_G, hg);
        write_reg(CFG_H_CAL_M, hm);
        write_reg(CFG_OFFSET_G, og);
        write_reg(CFG_OFFSET_M, om);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
    endtask

    task automatic directed_phases();
        send_phase('0, 1'b1, 1'b0);
        send_phase('0, 1'b0, 1'b1);
        send_phase('1, 1'b1, 1'b1);
        send_phase('1, 1'b0, 1'b0);
        send_phase(32'hAAAA_AAAA, 1'b1, 1'b0);
        send_phase(32'h5555_5555, 1'b0, 1'b1);
        // A request past the system modulus makes the total wrap below zero.
        send_phase(32'hF000_0000, 1'b1, 1'b1);
        send_phase(phase_giving_total(1'b1, '0), 1'b1, 1'b0);
        send_phase(phase_giving_total(1'b0, '0), 1'b0, 1'b0);
        send_phase(phase_giving_total(1'b1, PERIOD_G - 1), 1'b1, 1'b1);
        send_phase(phase_giving_total(1'b1, PERIOD_G), 1'b1, 1'b0);
        send_phase(phase_giving_total(1'b0, PERIOD_M - 1), 1'b0, 1'b1);
        send_phase(phase_giving_total(1'b0, PERIOD_M), 1'b0, 1'b0);
        // The last line of the frame wraps the start line back to zero.
        send_phase(phase_giving_total(1'b1, (LINES_G - 1) * PERIOD_G), 1'b1, 1'b1);
        send_phase(phase_giving_total(1'b0, (LINES_M - 1) * PERIOD_M), 1'b0, 1'b0);
        send_phase(phase_giving_total(1'b1, '1), 1'b1, 1'b0);
        send_phase(phase_giving_total(1'b0, '1), 1'b0, 1'b1);
        send_phase(phase_giving_total(1'b1, 32'h80), 1'b1, 1'b1);
    endtask

    task automatic random_phases(input int count);
        phase_pick_t       pick;
        int                roll;
        logic              sys_g;
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] lines;
        logic [DATA_W-1:0] phase;
        repeat (count) begin
            roll   = $urandom_range(7);
            pick   = (roll > 4) ? PICK_ANY : phase_pick_t'(roll);
            sys_g  = 1'($urandom_range(1));
            period = sys_g ? PERIOD_G : PERIOD_M;
            lines  = sys_g ? LINES_G : LINES_M;
            case (pick)
                PICK_LINE_EDGE:
                    phase = phase_giving_total(sys_g, $urandom_range(9776) * period
                                                      + $urandom_range(6) - 3);
                PICK_LINE_WRAP:
                    phase = phase_giving_total(sys_g, (lines * $urandom_range(3, 1) - 1) * period
                                                      + $urandom_range(period - 1));
                PICK_TOTAL_EDGE:
                    phase = phase_giving_total(sys_g, $urandom_range(1) ? $urandom_range(255)
                                                                        : ~$urandom_range(255));
                PICK_NEAR_MOD:
                    phase = (sys_g ? FRAME_MOD_G : FRAME_MOD_M) + $urandom_range(512) - 256;
                default:
                    phase = $urandom();
            endcase
            send_phase(phase, sys_g, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        item_ch.valid       <= 1'b0;
        item_ch.phase_value <= '0;
        item_ch.system_g    <= 1'b0;
        item_ch.blank_flag  <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        foreach (cfg_shadow[i])
            cfg_shadow[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        directed_phases();
        wait_results_drained();

        // A write to an unused index must leave every register alone.
        write_reg(CFG_IDX_UNUSED, $urandom());
        apply_calibration('1, '1, '1, '1);
        random_phases(100);
        wait_results_drained();

        apply_calibration($urandom(), $urandom(), $urandom(), $urandom());
        random_phases(100);
        wait_results_drained();

        // Sender keeps offering while the result side holds off, so the pipeline fills.
        tx_idle = 1'b0;
        apply_calibration('0, '0, '1, '1);
        hold_req = 1'b1;
        random_phases(100);
        wait_results_drained();

        rx_idle = 1'b0;
        apply_calibration($urandom(), $urandom(), $urandom(), $urandom());
        random_phases(150);
        wait_results_drained();

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        apply_calibration($urandom(), '1, '0, $urandom());
        random_phases(150);
        wait_results_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
